// ===== src/rthsv_pkg.sv =====
`default_nettype none
package rthsv_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned HueW     = 15;
	localparam int unsigned HueQW    = 12;
	localparam int unsigned SatQW    = 8;
	localparam int unsigned HueNumW  = 20;
	localparam int unsigned SatNumW  = 16;

	localparam logic [HueW-1:0] HueSector = 15'd7680;
	localparam logic [HueW-1:0] HueFull   = 15'd23040;

	// Word handed from cell to cell along the divider row
	typedef struct packed {
		logic                 defined;
		logic                 neg;
		logic [HueW-1:0]      base;
		logic [ChanW-1:0]     mx;
		logic [ChanW-1:0]     delta;
		logic [SatNumW-1:0]   srem;
		logic [SatQW-1:0]     sq;
		logic [HueNumW-1:0]   hrem;
		logic [HueQW-1:0]     hq;
	} div_word_t;

endpackage
`default_nettype wire

// ===== src/rthsv_cell.sv =====
`default_nettype none
module rthsv_cell import rthsv_pkg::*; #(
	parameter int unsigned SHIFT = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire div_word_t in_word,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      div_word_t out_word
);

	logic      v_q;
	div_word_t w_q;
	div_word_t nxt;
	logic [HueNumW-1:0] hden;
	logic [SatNumW-1:0] sden;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_word  = w_q;

	// One restoring step for the hue quotient, and for the saturation quotient when SHIFT < SatQW
	always_comb begin
		nxt  = in_word;
		hden = HueNumW'(in_word.delta) << SHIFT;
		sden = SatNumW'(in_word.mx) << SHIFT;
		if (in_word.hrem >= hden) begin
			nxt.hrem      = in_word.hrem - hden;
			nxt.hq[SHIFT] = 1'b1;
		end
		if (SHIFT < SatQW) begin
			if (in_word.srem >= sden) begin
				nxt.srem = in_word.srem - sden;
				nxt.sq[SHIFT % SatQW] = 1'b1;
			end
		end
	end

	// Advance when this cell is empty or the next cell can take the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			w_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== src/rgb_to_hsv_pixel.sv =====
`default_nettype none
// RGB to HSV converter: takes one pixel per clock and returns hue (1/64 degree),
// saturation, brightness and a hue-defined flag. It is built from one input
// stage finding max, min and the numerators, a row of 12 divider cells that each
// settle one bit of the hue quotient (the last eight also a saturation bit), and
// one output stage applying the sector base and wrap. Throughput is one pixel per
// cycle; each stage holds under backpressure, empty stages fill independently.
module rgb_to_hsv_pixel import rthsv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire logic [ChanW-1:0] red,
	input  wire logic [ChanW-1:0] green,
	input  wire logic [ChanW-1:0] blue,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic [HueW-1:0]  hue,
	output      logic [ChanW-1:0] saturation,
	output      logic [ChanW-1:0] brightness,
	output      logic             hue_defined
);

	localparam int unsigned NCell = HueQW;

	logic [ChanW-1:0] mx, mn, pos, neg_v, diff;
	div_word_t        front;
	logic             v_s1;
	div_word_t        w_s1;
	logic             rdy_s1;

	logic      cv   [NCell+1];
	logic      crdy [NCell+1];
	div_word_t cw   [NCell+1];

	logic      v_q;
	logic      rdy_out;
	logic [15:0] hsum;
	logic [HueW-1:0]  hue_q;
	logic [ChanW-1:0] sat_q, bri_q;
	logic             def_q;

	// Find extremes, sector and numerators
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		front       = '0;
		front.mx    = mx;
		front.delta = mx - mn;
		front.defined = (mx != '0) && (mx != mn);
		priority if (red == mx) begin
			front.base = '0;       pos = green; neg_v = blue;
		end else if (green == mx) begin
			front.base = HueSector; pos = blue; neg_v = red;
		end else begin
			front.base = HueSector << 1; pos = red; neg_v = green;
		end
		front.neg = neg_v > pos;
		diff = front.neg ? (neg_v - pos) : (pos - neg_v);
		front.hrem = (HueNumW'(diff) << 12) - (HueNumW'(diff) << 8);
		front.srem = (SatNumW'(front.delta) << 8) - SatNumW'(front.delta);
	end

	assign in_ready = rdy_s1;
	assign rdy_s1   = !v_s1 || crdy[0];

	// Hold the front stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			w_s1 <= front;
		end
	end

	assign cv[0] = v_s1;
	assign cw[0] = w_s1;

	// Divider row, most significant quotient bit first
	for (genvar i = 0; i < NCell; i++) begin : g_cell
		rthsv_cell #(.SHIFT(NCell - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (crdy[i]),
			.in_word   (cw[i]),
			.out_valid (cv[i+1]),
			.out_ready (crdy[i+1]),
			.out_word  (cw[i+1])
		);
	end

	assign crdy[NCell] = rdy_out;
	assign rdy_out     = !v_q || out_ready;

	// Apply sector base and wrap below zero
	always_comb begin
		if (cw[NCell].neg) begin
			hsum = {1'b0, cw[NCell].base} - 16'(cw[NCell].hq);
		end else begin
			hsum = {1'b0, cw[NCell].base} + 16'(cw[NCell].hq);
		end
		if (hsum[15]) begin
			hsum = hsum + {1'b0, HueFull};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_out) begin
			v_q <= cv[NCell];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && cv[NCell]) begin
			def_q <= cw[NCell].defined;
			bri_q <= cw[NCell].mx;
			hue_q <= cw[NCell].defined ? hsum[HueW-1:0] : '0;
			sat_q <= cw[NCell].defined ? cw[NCell].sq : '0;
		end
	end

	assign out_valid   = v_q;
	assign hue         = hue_q;
	assign saturation  = sat_q;
	assign brightness  = bri_q;
	assign hue_defined = def_q;

endmodule
`default_nettype wire

// ===== src/rthsv_checker.sv =====
`default_nettype none
module rthsv_checker import rthsv_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [HueW-1:0]  hue,
	input wire logic [ChanW-1:0] saturation,
	input wire logic [ChanW-1:0] brightness,
	input wire logic             hue_defined
);

	// Undefined hue reads as zero with no saturation
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hue_defined |-> hue == '0 && saturation == '0)
		else $error("undefined hue not zeroed");

	// Hue stays inside one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue < HueFull)
		else $error("hue out of range");

	// A colored pixel has nonzero saturation and brightness
	a_defined_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_defined |-> saturation != '0 && brightness != '0)
		else $error("defined hue with zero saturation");

	// Stalled transaction stays valid and holds its hue and saturation
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation))
		else $error("stalled transaction changed");

endmodule

bind rgb_to_hsv_pixel rthsv_checker u_rthsv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.hue         (hue),
	.saturation  (saturation),
	.brightness  (brightness),
	.hue_defined (hue_defined)
);
`default_nettype wire
